// File: hdl/s2sbp_pkg.sv
// Shared types and constants for the SECS-II sensor body parser.
package s2sbp_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  // Entry counter width, wide enough to hold MAX_ENTRIES itself.
  localparam int unsigned ENT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LEN_W       = 24;

  localparam int unsigned TS_BYTES    = 8;
  localparam int unsigned CNT_BYTES   = 2;
  localparam int unsigned ID_BYTES    = 2;
  localparam int unsigned VAL_BYTES   = 4;

  localparam int unsigned OQ_DEPTH    = 4;
  localparam int unsigned OQ_PTR_W    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_STAMP  = 2'd0,
    KIND_SENSOR = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       body_start;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] stamp;
    logic [15:0] dev_id;
    logic [31:0] value_bits;
    logic [6:0]  entry_count;
    logic        last;
  } out_word_t;

  // Words produced by one accepted input byte.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } res_push_t;

endpackage

// File: hdl/s2sbp_core.sv
// Parser state machine: takes one body byte per cycle while take_i is high and forms up to two result words.
module s2sbp_core import s2sbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_word_t  in_data_i,
  output res_push_t push_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ROOT_LEN, PH_TS_FMT, PH_TS_LEN, PH_TS_DATA,
    PH_CNT_FMT, PH_CNT_LEN, PH_CNT_DATA, PH_LIST_FMT, PH_LIST_LEN,
    PH_ENT_FMT, PH_ENT_LEN, PH_ID_FMT, PH_ID_LEN, PH_ID_DATA,
    PH_VAL_FMT, PH_VAL_LEN, PH_VAL_DATA, PH_SKIP
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         idx_q, idx_d;
  logic [1:0]         left_q, left_d;
  logic [LEN_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   want_q, want_d;
  logic [ENT_W-1:0]   ent_q, ent_d;
  logic [63:0]        vs_q, vs_d;
  logic [15:0]        id_q, id_d;

  logic       fmt, comp;
  phase_e     fmt_phase;
  logic       e_ts, e_ent, e_done, e_err;
  logic [7:0] b;
  out_word_t  r_ts, r_ent, r_done, r_err;

  assign b = in_data_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    left_d    = left_q;
    acc_d     = acc_q;
    want_d    = want_q;
    ent_d     = ent_q;
    vs_d      = vs_q;
    id_d      = id_q;
    fmt       = 1'b0;
    fmt_phase = PH_IDLE;
    comp      = 1'b0;
    e_ts      = 1'b0;
    e_ent     = 1'b0;
    e_done    = 1'b0;
    e_err     = 1'b0;

    if (in_data_i.body_start) begin
      idx_d     = '0;
      acc_d     = '0;
      want_d    = '0;
      ent_d     = '0;
      vs_d      = '0;
      id_d      = '0;
      fmt       = 1'b1;
      fmt_phase = PH_ROOT_LEN;
    end else begin
      unique case (phase_q)
        PH_TS_FMT: begin
          fmt = 1'b1; fmt_phase = PH_TS_LEN;
        end
        PH_CNT_FMT: begin
          fmt = 1'b1; fmt_phase = PH_CNT_LEN;
        end
        PH_LIST_FMT: begin
          fmt = 1'b1; fmt_phase = PH_LIST_LEN;
        end
        PH_ENT_FMT: begin
          fmt = 1'b1; fmt_phase = PH_ENT_LEN;
        end
        PH_ID_FMT: begin
          fmt = 1'b1; fmt_phase = PH_ID_LEN;
        end
        PH_VAL_FMT: begin
          fmt = 1'b1; fmt_phase = PH_VAL_LEN;
        end
        PH_ROOT_LEN, PH_TS_LEN, PH_CNT_LEN, PH_LIST_LEN,
        PH_ENT_LEN, PH_ID_LEN, PH_VAL_LEN: begin
          acc_d  = {acc_q[LEN_W-9:0], b};
          left_d = (left_q != 2'd0) ? left_q - 2'd1 : left_q;
          comp   = (left_d == 2'd0);
        end
        PH_TS_DATA: begin
          vs_d  = {vs_q[55:0], b};
          idx_d = idx_q + 4'd1;
          if (idx_d >= 4'(TS_BYTES)) begin
            e_ts    = 1'b1;
            phase_d = PH_CNT_FMT;
          end
        end
        PH_CNT_DATA: begin
          idx_d = idx_q + 4'd1;
          if (idx_d >= 4'(CNT_BYTES)) phase_d = PH_LIST_FMT;
        end
        PH_ID_DATA: begin
          id_d  = {id_q[7:0], b};
          idx_d = idx_q + 4'd1;
          if (idx_d >= 4'(ID_BYTES)) phase_d = PH_VAL_FMT;
        end
        PH_VAL_DATA: begin
          vs_d  = {32'd0, vs_q[23:0], b};
          idx_d = idx_q + 4'd1;
          if (idx_d >= 4'(VAL_BYTES)) begin
            ent_d = ent_q + 1'b1;
            e_ent = 1'b1;
            if ((LEN_W'(ent_d) >= want_q) || (ent_d >= ENT_W'(MAX_ENTRIES))) begin
              e_done  = 1'b1;
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_ENT_FMT;
            end
          end
        end
        default: ;
      endcase
    end

    // A format byte opens an item; zero length bytes finish its length at once.
    if (fmt) begin
      left_d  = b[1:0];
      acc_d   = '0;
      phase_d = fmt_phase;
      comp    = (b[1:0] == 2'd0);
    end

    if (comp) begin
      unique case (phase_d)
        PH_ROOT_LEN: phase_d = PH_TS_FMT;
        PH_TS_LEN: begin
          if (acc_d != LEN_W'(TS_BYTES)) begin
            e_err = 1'b1; phase_d = PH_SKIP;
          end else begin
            idx_d = '0; vs_d = '0; phase_d = PH_TS_DATA;
          end
        end
        PH_CNT_LEN: begin
          if (acc_d != LEN_W'(CNT_BYTES)) begin
            e_err = 1'b1; phase_d = PH_SKIP;
          end else begin
            idx_d = '0; vs_d = '0; phase_d = PH_CNT_DATA;
          end
        end
        PH_LIST_LEN: begin
          want_d = acc_d;
          ent_d  = '0;
          if (acc_d == '0) begin
            e_done = 1'b1; phase_d = PH_SKIP;
          end else begin
            phase_d = PH_ENT_FMT;
          end
        end
        PH_ENT_LEN: phase_d = PH_ID_FMT;
        PH_ID_LEN: begin
          if (acc_d != LEN_W'(ID_BYTES)) begin
            e_err = 1'b1; phase_d = PH_SKIP;
          end else begin
            id_d = '0; idx_d = '0; vs_d = '0; phase_d = PH_ID_DATA;
          end
        end
        PH_VAL_LEN: begin
          if (acc_d != LEN_W'(VAL_BYTES)) begin
            e_err = 1'b1; phase_d = PH_SKIP;
          end else begin
            idx_d = '0; vs_d = '0; phase_d = PH_VAL_DATA;
          end
        end
        default: phase_d = PH_SKIP;
      endcase
    end
  end

  always_comb begin
    r_ts             = '0;
    r_ts.kind        = KIND_STAMP;
    r_ts.stamp       = vs_d;
    r_ts.entry_count = 7'(ent_d);
    r_ent             = '0;
    r_ent.kind        = KIND_SENSOR;
    r_ent.dev_id      = id_d;
    r_ent.value_bits  = vs_d[31:0];
    r_ent.entry_count = 7'(ent_d);
    r_done             = '0;
    r_done.kind        = KIND_DONE;
    r_done.entry_count = 7'(ent_d);
    r_err             = '0;
    r_err.kind        = KIND_ERROR;
    r_err.entry_count = 7'(ent_d);

    push_o = '0;
    priority if (e_ent) begin
      push_o.first = r_ent;
      if (e_done) begin
        push_o.second      = r_done;
        push_o.second.last = 1'b1;
        push_o.count       = 2'd2;
      end else begin
        push_o.first.last = 1'b1;
        push_o.count      = 2'd1;
      end
    end else if (e_ts) begin
      push_o.first      = r_ts;
      push_o.first.last = 1'b1;
      push_o.count      = 2'd1;
    end else if (e_done) begin
      push_o.first      = r_done;
      push_o.first.last = 1'b1;
      push_o.count      = 2'd1;
    end else if (e_err) begin
      push_o.first      = r_err;
      push_o.first.last = 1'b1;
      push_o.count      = 2'd1;
    end
    if (!take_i) push_o.count = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      left_q  <= '0;
      acc_q   <= '0;
      want_q  <= '0;
      ent_q   <= '0;
      vs_q    <= '0;
      id_q    <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      want_q  <= want_d;
      ent_q   <= ent_d;
      vs_q    <= vs_d;
      id_q    <= id_d;
    end
  end

endmodule

// File: hdl/s2sbp_outq.sv
// Result queue: takes up to two words per cycle and hands out one while out_ready_i is high.
module s2sbp_outq import s2sbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  out_word_t             mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wp_q, rp_q;
  logic [OQ_CNT_W-1:0]   cnt_q;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wp_next;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  // Room for the worst case of two words from the next byte.
  assign room_o      = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign wp_next     = wp_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wp_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wp_next] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + OQ_PTR_W'(push_i.count);
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + OQ_CNT_W'(push_i.count) - OQ_CNT_W'(pop);
    end
  end

endmodule

// File: hdl/secs2_sensor_body_parser.sv
// Top level of the SECS-II sensor body parser.
//
// The input channel carries one body byte per word, with body_start set on
// the first byte of each message body; that byte restarts the parser.
// The output channel carries result words: a timestamp record, one record
// per sensor entry, a done record, or a length error record. The last flag
// marks the final word caused by one input byte.
// One byte is taken per cycle while in_ready_o is high. The parser state
// updates at the accepting edge and the words it causes enter a four-word
// result queue, from whose head they are offered on out_valid_o.
// A byte can cause two words (last sensor entry plus done), so in_ready_o
// stays high while the queue has room for two; with the receiver ready the
// block sustains one byte per cycle. When the receiver stalls the queue
// fills and in_ready_o drops until words drain.
// Reset clears the parser to idle and empties the queue; bytes without
// body_start are then ignored until a body begins.
module secs2_sensor_body_parser import s2sbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      take;
  res_push_t push;

  assign take = in_valid_i && in_ready_o;

  s2sbp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  s2sbp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("queue empty but input not ready");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_DONE) |-> out_data_o.last)
    else $error("done word not marked last");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_ERROR) |-> out_data_o.last)
    else $error("error word not marked last");

  a_push_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> take)
    else $error("result pushed without an accepted byte");
`endif

endmodule
